>>> rtl/cts_pkg.sv
// cts_pkg: shared types and constants of the cooperative task scheduler
// holds op and status codes, the table entry layout, the controller states
// and the controller to datapath command and status structs; no dependencies
`default_nettype none

package cts_pkg;

    // default table depth, overridable from the top level
    localparam int DEF_MAX_TASKS = 16;

    // most results that one dispatch item may return
    localparam int RESULT_CAP = 16;
    localparam int RUN_W      = $clog2(RESULT_CAP + 1);

    // item operations
    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TICK     = 2'd2,
        OP_DISPATCH = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [2:0] {
        STAT_DONE     = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_BAD_SLOT = 3'd2,
        STAT_RUN      = 3'd3,
        STAT_NONE     = 3'd4
    } status_t;

    // one task table entry as stored in the table memory
    typedef struct packed {
        logic [7:0]  handler;
        logic [31:0] countdown;
        logic [31:0] period;
        logic [7:0]  pending;
    } cts_entry_t;

    localparam int ENTRY_W = $bits(cts_entry_t);

    // controller states
    typedef enum logic {
        S_IDLE  = 1'b0,
        S_SWEEP = 1'b1
    } cts_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic do_add;
        logic do_full;
        logic do_bad;
        logic begin_sweep;
        logic step;
        logic finish;
    } cts_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic slot_bad;
        logic sweep_done;
    } cts_stat_t;

endpackage

`default_nettype wire

>>> rtl/cooperative_task_scheduler.sv
// cooperative_task_scheduler: top level of the time-triggered task scheduler
// joins cts_ctrl and cts_datapath; uses cts_pkg
//
//   channel   handshake             payload
//   item in   start, busy           op, handler_id, first_delay, period, slot_index
//   result    valid (one cycle)     status, task_handler, slot, last
//
// add, a full table and a bad slot: result in the cycle after the accepting edge, busy stays low
// tick, delete and dispatch sweep the table one entry a cycle through the registered read port;
// entries swept are task_count for tick and dispatch, task_count - slot_index - 1 for delete
// busy is then high for the sweep, also when no entry is swept
// the final result shows in the first cycle after busy falls, when a new item may already start
// reset clears the task count; table contents are written before they are read
// results cannot be stalled, each stands on the ports for exactly one cycle
`default_nettype none

module cooperative_task_scheduler
    import cts_pkg::*;
#(
    parameter int MAX_TASKS = DEF_MAX_TASKS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  handler_id,
    input  wire logic [31:0] first_delay,
    input  wire logic [31:0] period,
    input  wire logic [3:0]  slot_index,
    output logic             valid,
    output logic [2:0]       status,
    output logic [7:0]       task_handler,
    output logic [3:0]       slot,
    output logic             last
);

    cts_cmd_t  cmd;
    cts_stat_t dp_stat;

    // controller
    cts_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .op      (op),
        .dp_stat (dp_stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    // datapath
    cts_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .dp_stat      (dp_stat),
        .op           (op),
        .handler_id   (handler_id),
        .first_delay  (first_delay),
        .period       (period),
        .slot_index   (slot_index),
        .valid        (valid),
        .status       (status),
        .task_handler (task_handler),
        .slot         (slot),
        .last         (last)
    );

`ifndef ASSERT_OFF
    // a finished sweep always leaves its final result on the ports
    a_sweep_ends_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (valid && last))
        else $error("sweep ended without a final result");

    // only run results may be followed by more results of the same item
    a_not_last_is_run: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !last) |-> (status == STAT_RUN))
        else $error("non-final result is not a run");

    // an add answers in the next cycle with its only result
    a_add_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_ADD)) |=> (valid && last && !busy))
        else $error("add did not answer in one cycle");

    // a none-pending result carries no handler and no slot
    a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && (status == STAT_NONE)) |-> ((task_handler == 8'd0) && (slot == 4'd0)))
        else $error("none-pending result carries payload");
`endif

endmodule

`default_nettype wire

>>> rtl/cts_ram.sv
// cts_ram: generic single write port, single read port memory
// read data is registered; no dependencies
`default_nettype none

module cts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/cts_ctrl.sv
// cts_ctrl: controller state machine of the task scheduler
// decodes an accepted item and sequences the table sweep; uses cts_pkg
`default_nettype none

module cts_ctrl
    import cts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] op,
    input  wire cts_stat_t  dp_stat,
    output cts_cmd_t        cmd,
    output logic            busy
);

    cts_state_t state_reg;
    cts_state_t state_next;
    logic       accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg == S_SWEEP);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(op))
                        OP_ADD:    state_next = S_IDLE;
                        OP_DELETE: state_next = dp_stat.slot_bad ? S_IDLE : S_SWEEP;
                        default:   state_next = S_SWEEP;
                    endcase
                end
            end
            S_SWEEP:
            begin
                if (dp_stat.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(op))
                        OP_ADD:
                        begin
                            cmd.do_add  = !dp_stat.full;
                            cmd.do_full = dp_stat.full;
                        end
                        OP_DELETE:
                        begin
                            cmd.do_bad      = dp_stat.slot_bad;
                            cmd.begin_sweep = !dp_stat.slot_bad;
                        end
                        default: cmd.begin_sweep = 1'b1;
                    endcase
                end
            end
            S_SWEEP:
            begin
                cmd.step   = !dp_stat.sweep_done;
                cmd.finish = dp_stat.sweep_done;
            end
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/cts_datapath.sv
// cts_datapath: task table, sweep pointers and result register
// the table lives in a cts_ram instance; commands come from cts_ctrl; uses cts_pkg
`default_nettype none

module cts_datapath
    import cts_pkg::*;
#(
    parameter int MAX_TASKS = DEF_MAX_TASKS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cts_cmd_t    cmd,
    output cts_stat_t        dp_stat,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  handler_id,
    input  wire logic [31:0] first_delay,
    input  wire logic [31:0] period,
    input  wire logic [3:0]  slot_index,
    output logic             valid,
    output logic [2:0]       status,
    output logic [7:0]       task_handler,
    output logic [3:0]       slot,
    output logic             last
);

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int XW = (CW > 4) ? CW : 4;

    // table count, sweep read and write pointers
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    rd_reg, rd_next;
    logic [CW-1:0]    wr_reg, wr_next;
    logic             vld_reg, vld_next;
    op_t              op_reg, op_next;
    logic [RUN_W-1:0] runs_reg, runs_next;

    // run result held back until it is known whether it is the final one
    logic             hold_vld_reg, hold_vld_next;
    logic [7:0]       hold_handler_reg, hold_handler_next;
    logic [3:0]       hold_slot_reg, hold_slot_next;

    // result register
    logic             valid_reg, valid_next;
    status_t          status_reg, status_next;
    logic [7:0]       handler_reg, handler_next;
    logic [3:0]       slot_reg, slot_next;
    logic             last_reg, last_next;

    // table memory ports
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IW-1:0]    ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    cts_entry_t       ent;
    cts_entry_t       proc_ent;
    cts_entry_t       new_ent;
    logic             run;
    logic             drop;
    logic [XW-1:0]    wr_wide;
    logic [XW-1:0]    count_wide;

    cts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign wr_wide    = XW'(wr_reg);
    assign count_wide = XW'(count_reg);

    // status to the controller
    assign dp_stat.full       = (count_reg == CW'(MAX_TASKS));
    assign dp_stat.slot_bad   = (XW'(slot_index) >= count_wide);
    assign dp_stat.sweep_done = (rd_reg >= count_reg) && !vld_reg;

    // new entry built from the item fields
    always_comb
    begin
        new_ent.handler   = handler_id;
        new_ent.countdown = first_delay;
        new_ent.period    = period;
        new_ent.pending   = 8'd0;
    end

    // per-entry update of the entry just read
    always_comb
    begin
        ent      = cts_entry_t'(ram_rdata);
        proc_ent = ent;
        run      = 1'b0;
        drop     = 1'b0;
        case (op_reg)
            OP_TICK:
            begin
                if (ent.countdown != 32'd0)
                begin
                    proc_ent.countdown = ent.countdown - 32'd1;
                end
                else
                begin
                    proc_ent.countdown = ent.period;
                    if (ent.pending != 8'hFF)
                    begin
                        proc_ent.pending = ent.pending + 8'd1;
                    end
                end
            end
            OP_DISPATCH:
            begin
                if ((runs_reg < RUN_W'(RESULT_CAP)) && (ent.pending != 8'd0))
                begin
                    run              = 1'b1;
                    proc_ent.pending = ent.pending - 8'd1;
                    drop             = (ent.period == 32'd0);
                end
            end
            default: proc_ent = ent;
        endcase
    end

    // next-state logic of the datapath
    always_comb
    begin
        count_next        = count_reg;
        rd_next           = rd_reg;
        wr_next           = wr_reg;
        vld_next          = 1'b0;
        op_next           = op_reg;
        runs_next         = runs_reg;
        hold_vld_next     = hold_vld_reg;
        hold_handler_next = hold_handler_reg;
        hold_slot_next    = hold_slot_reg;
        valid_next        = 1'b0;
        status_next       = status_reg;
        handler_next      = handler_reg;
        slot_next         = slot_reg;
        last_next         = last_reg;
        ram_we            = 1'b0;
        ram_waddr         = wr_reg[IW-1:0];
        ram_wdata         = proc_ent;
        ram_raddr         = rd_reg[IW-1:0];

        // append a task
        if (cmd.do_add)
        begin
            ram_we       = 1'b1;
            ram_waddr    = count_reg[IW-1:0];
            ram_wdata    = new_ent;
            count_next   = count_reg + CW'(1);
            valid_next   = 1'b1;
            status_next  = STAT_DONE;
            handler_next = 8'd0;
            slot_next    = count_wide[3:0];
            last_next    = 1'b1;
        end

        // rejected items
        if (cmd.do_full || cmd.do_bad)
        begin
            valid_next   = 1'b1;
            status_next  = cmd.do_full ? STAT_FULL : STAT_BAD_SLOT;
            handler_next = 8'd0;
            slot_next    = 4'd0;
            last_next    = 1'b1;
        end

        // set up a sweep; delete starts copying from the slot after the victim
        if (cmd.begin_sweep)
        begin
            op_next       = op_t'(op);
            runs_next     = '0;
            hold_vld_next = 1'b0;
            if (op_t'(op) == OP_DELETE)
            begin
                rd_next = CW'({1'b0, slot_index} + 5'd1);
                wr_next = CW'(slot_index);
            end
            else
            begin
                rd_next = '0;
                wr_next = '0;
            end
        end

        // one sweep cycle: issue a read, write back the entry read before
        if (cmd.step)
        begin
            if (rd_reg < count_reg)
            begin
                vld_next = 1'b1;
                rd_next  = rd_reg + CW'(1);
            end
            if (vld_reg)
            begin
                ram_we = !drop;
                if (!drop)
                begin
                    wr_next = wr_reg + CW'(1);
                end
                if (run)
                begin
                    runs_next = runs_reg + RUN_W'(1);
                    if (hold_vld_reg)
                    begin
                        valid_next   = 1'b1;
                        status_next  = STAT_RUN;
                        handler_next = hold_handler_reg;
                        slot_next    = hold_slot_reg;
                        last_next    = 1'b0;
                    end
                    hold_vld_next     = 1'b1;
                    hold_handler_next = ent.handler;
                    hold_slot_next    = wr_wide[3:0];
                end
            end
        end

        // end of sweep: new count and the final result
        if (cmd.finish)
        begin
            count_next = wr_reg;
            valid_next = 1'b1;
            last_next  = 1'b1;
            if (op_reg == OP_DISPATCH)
            begin
                status_next  = hold_vld_reg ? STAT_RUN : STAT_NONE;
                handler_next = hold_vld_reg ? hold_handler_reg : 8'd0;
                slot_next    = hold_vld_reg ? hold_slot_reg : 4'd0;
            end
            else
            begin
                status_next  = STAT_DONE;
                handler_next = 8'd0;
                slot_next    = 4'd0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            rd_reg       <= '0;
            wr_reg       <= '0;
            vld_reg      <= 1'b0;
            op_reg       <= OP_ADD;
            runs_reg     <= '0;
            hold_vld_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            rd_reg       <= rd_next;
            wr_reg       <= wr_next;
            vld_reg      <= vld_next;
            op_reg       <= op_next;
            runs_reg     <= runs_next;
            hold_vld_reg <= hold_vld_next;
            valid_reg    <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_handler_reg <= hold_handler_next;
        hold_slot_reg    <= hold_slot_next;
        status_reg       <= status_next;
        handler_reg      <= handler_next;
        slot_reg         <= slot_next;
        last_reg         <= last_next;
    end

    assign valid        = valid_reg;
    assign status       = status_reg;
    assign task_handler = handler_reg;
    assign slot         = slot_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire
